// ===== hdl/fqrc_pkg.sv =====
`timescale 1ns / 1ps
package fqrc_pkg;

  // Build defaults
  localparam int FQRC_MAX_LINE  = 256;
  localparam int FQRC_OUT_LANES = 8;
  localparam int FQRC_MAX_LANES = 8;

  // Characters
  localparam logic [7:0] CHAR_NL   = 8'h0a;
  localparam logic [7:0] CHAR_PLUS = 8'h2b;

  // Status codes
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_NON_BASE  = 3'd1;
  localparam logic [2:0] STATUS_NO_PLUS   = 3'd2;
  localparam logic [2:0] STATUS_TRUNCATED = 3'd3;
  localparam logic [2:0] STATUS_TOO_LONG  = 3'd4;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SEQ    = 2'd1,
    PH_PLUS   = 2'd2,
    PH_QUAL   = 2'd3
  } fqrc_phase_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PREP  = 4'b0010,
    ST_ISSUE = 4'b0100,
    ST_DRAIN = 4'b1000
  } fqrc_state_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } fqrc_in_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last;
    logic [2:0]  status;
  } fqrc_out_t;

  // IUPAC complement, case kept; zero for a non-base byte
  function automatic logic [7:0] fqrc_iupac_comp(input logic [7:0] b);
    logic       lower;
    logic [7:0] up;
    logic [7:0] r;
    lower = (b >= 8'h61) && (b <= 8'h7a);
    up    = lower ? (b - 8'd32) : b;
    case (up)
      8'h41:   r = 8'h54; // A -> T
      8'h54:   r = 8'h41; // T -> A
      8'h43:   r = 8'h47; // C -> G
      8'h47:   r = 8'h43; // G -> C
      8'h4e:   r = 8'h4e; // N
      8'h4b:   r = 8'h4d; // K -> M
      8'h4d:   r = 8'h4b; // M -> K
      8'h53:   r = 8'h53; // S
      8'h57:   r = 8'h57; // W
      8'h59:   r = 8'h52; // Y -> R
      8'h52:   r = 8'h59; // R -> Y
      8'h42:   r = 8'h56; // B -> V
      8'h56:   r = 8'h42; // V -> B
      8'h44:   r = 8'h48; // D -> H
      8'h48:   r = 8'h44; // H -> D
      default: r = 8'h00;
    endcase
    if (r == 8'h00) begin
      return 8'h00;
    end
    return lower ? (r + 8'd32) : r;
  endfunction

  function automatic fqrc_out_t fqrc_status_item(input logic [2:0] code);
    fqrc_out_t item;
    item            = '0;
    item.last       = 1'b1;
    item.status     = code;
    return item;
  endfunction

  function automatic fqrc_out_t fqrc_byte_item(input logic [7:0] b);
    fqrc_out_t item;
    item                = '0;
    item.out_bytes[7:0] = b;
    item.byte_count     = 4'd1;
    item.last           = 1'b1;
    return item;
  endfunction

endpackage

// ===== hdl/fqrc_line_buf.sv =====
`timescale 1ns / 1ps
module fqrc_line_buf import fqrc_pkg::*; #(
  parameter int MAX_LINE  = FQRC_MAX_LINE,
  parameter int OUT_LANES = FQRC_OUT_LANES,
  localparam int ROWS     = (MAX_LINE + OUT_LANES - 1) / OUT_LANES,
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int RC_W     = ROW_W + 1,
  localparam int LANE_W   = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1
) (
  input  logic                               clk_i,
  input  logic                               wr_en_i,
  input  logic [LANE_W-1:0]                  wr_bank_i,
  input  logic [ROW_W-1:0]                   wr_row_i,
  input  logic [7:0]                         wr_data_i,
  input  logic                               rd_en_i,
  input  logic [RC_W-1:0]                    rd_top_row_i,
  input  logic [LANE_W-1:0]                  rd_top_bank_i,
  output logic [FQRC_MAX_LANES-1:0][7:0]     lane_data_o
);

  logic [7:0] rdata_q [OUT_LANES];

  // One bank per output lane; byte i lives in bank i mod lanes, row i / lanes
  for (genvar b = 0; b < OUT_LANES; b++) begin : g_bank
    logic [7:0]      mem [ROWS];
    logic [RC_W-1:0] row_ext;
    logic            row_ok;

    // Banks above the top bank hold the group one row down
    assign row_ext = rd_top_row_i -
                     ((LANE_W'(b) > rd_top_bank_i) ? RC_W'(1) : RC_W'(0));
    assign row_ok  = !row_ext[RC_W-1] && (row_ext < RC_W'(ROWS));

    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_bank_i == LANE_W'(b))) begin
        mem[wr_row_i] <= wr_data_i;
      end
      if (rd_en_i && row_ok) begin
        rdata_q[b] <= mem[row_ext[ROW_W-1:0]];
      end
    end
  end

  // Rotate banks into lanes: lane j takes bank (top - j) mod lanes
  always_comb begin
    logic [LANE_W-1:0] src;
    src         = '0;
    lane_data_o = '0;
    for (int j = 0; j < FQRC_MAX_LANES; j++) begin
      if (j < OUT_LANES) begin
        if (LANE_W'(j) <= rd_top_bank_i) begin
          src = rd_top_bank_i - LANE_W'(j);
        end else begin
          src = rd_top_bank_i + LANE_W'(OUT_LANES - j);
        end
        lane_data_o[j] = rdata_q[src];
      end
    end
  end

endmodule

// ===== hdl/fastq_reverse_complement_unit.sv =====
`timescale 1ns / 1ps
// FASTQ reverse-complement streamer.
// Input channel: one transaction per FASTQ text byte (in_byte), or an
// end-of-stream marker (end_of_input set). Output channel: one transaction
// per result, up to OUT_LANES bytes packed low byte first, with byte_count,
// last (final result of the input byte) and status.
// Header and plus line bytes come out in the cycle after they are taken, one
// input transaction per cycle unless input is stalled; sequence and quality
// bytes are buffered at one per cycle too and cause no result. The newline
// that ends a buffered line starts a drain through the prep and issue
// states, then one result per cycle unless stalled, ceil((n + 1) / OUT_LANES)
// results for n buffered bytes, paced by the single read port of each line
// buffer bank. An error gives one status-only result and then repeats it for
// every later transaction; a clean end of stream between records gives one
// status-ok result, one inside a quality line drains that line, and later
// transactions are dropped. Reset clears all control state at once; the line
// buffer needs no clearing pass. A stalled receiver holds the output
// register; input is stalled during the drain and while it cannot load.
module fastq_reverse_complement_unit import fqrc_pkg::*; #(
  parameter int MAX_LINE  = FQRC_MAX_LINE,
  parameter int OUT_LANES = FQRC_OUT_LANES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  fqrc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output fqrc_out_t out_data_o
);

  localparam int ROWS   = (MAX_LINE + OUT_LANES - 1) / OUT_LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RC_W   = ROW_W + 1;
  localparam int LANE_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
  localparam int FILL_W = $clog2(MAX_LINE + 1);

  fqrc_state_e state_q, state_d;
  fqrc_phase_e phase_q, phase_d;
  logic              started_q, started_d;
  logic [2:0]        err_q, err_d;
  logic              fin_q, fin_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [LANE_W-1:0] wbank_q, wbank_d;
  logic [RC_W-1:0]   wrow_q, wrow_d;
  logic [LANE_W-1:0] tb_q, tb_d;
  logic [RC_W-1:0]   rc_q, rc_d;
  logic [FILL_W-1:0] rem_q, rem_d;
  logic              out_valid_q, out_valid_d;
  fqrc_out_t         out_q, out_d;

  logic              out_free;
  logic              in_take;
  logic [7:0]        in_b;
  logic              in_nl;
  logic [7:0]        in_comp;
  logic              wr_en;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [LANE_W-1:0] top_bank;
  logic [RC_W-1:0]   top_row;
  logic              rem_full;
  fqrc_out_t         drain_item;
  logic [FQRC_MAX_LANES-1:0][7:0] lane_data;

  // The output register can load when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_b       = in_data_i.in_byte;
  assign in_nl      = (in_b == CHAR_NL);
  assign in_comp    = fqrc_iupac_comp(in_b);

  // Last buffered byte sits one position below the write pointer
  assign top_bank = (wbank_q == '0) ? LANE_W'(OUT_LANES - 1) : (wbank_q - 1'b1);
  assign top_row  = (wbank_q == '0) ? (wrow_q - 1'b1) : wrow_q;

  fqrc_line_buf #(
    .MAX_LINE  (MAX_LINE),
    .OUT_LANES (OUT_LANES)
  ) u_line_buf (
    .clk_i         (clk_i),
    .wr_en_i       (wr_en),
    .wr_bank_i     (wbank_q),
    .wr_row_i      (wrow_q[ROW_W-1:0]),
    .wr_data_i     (wr_data),
    .rd_en_i       (rd_en),
    .rd_top_row_i  (rc_d),
    .rd_top_bank_i (tb_q),
    .lane_data_o   (lane_data)
  );

  // Build one drain result from the lanes read for this row group
  assign rem_full = (rem_q >= FILL_W'(OUT_LANES));

  always_comb begin
    drain_item = '0;
    for (int j = 0; j < FQRC_MAX_LANES; j++) begin
      if (j < OUT_LANES) begin
        if (rem_full || (FILL_W'(j) < rem_q)) begin
          drain_item.out_bytes[8*j +: 8] = lane_data[j];
        end else if (FILL_W'(j) == rem_q) begin
          drain_item.out_bytes[8*j +: 8] = CHAR_NL;
        end
      end
    end
    drain_item.byte_count = rem_full ? 4'(OUT_LANES) : (4'(rem_q) + 4'd1);
    drain_item.last       = !rem_full;
    drain_item.status     = STATUS_OK;
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    started_d   = started_q;
    err_d       = err_q;
    fin_d       = fin_q;
    fill_d      = fill_q;
    wbank_d     = wbank_q;
    wrow_d      = wrow_q;
    tb_d        = tb_q;
    rc_d        = rc_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    wr_data     = in_b;
    rd_en       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          if (err_q != STATUS_OK) begin
            // Halted: repeat the error report
            out_d       = fqrc_status_item(err_q);
            out_valid_d = 1'b1;
          end else if (fin_q) begin
            // Finished: drop the transaction
          end else if (in_data_i.end_of_input) begin
            if ((phase_q == PH_HEADER) && !started_q) begin
              fin_d       = 1'b1;
              out_d       = fqrc_status_item(STATUS_OK);
              out_valid_d = 1'b1;
            end else if ((phase_q == PH_QUAL) && started_q) begin
              // Complete the unterminated quality line
              phase_d = PH_HEADER;
              fin_d   = 1'b1;
              state_d = ST_PREP;
            end else begin
              err_d       = STATUS_TRUNCATED;
              out_d       = fqrc_status_item(STATUS_TRUNCATED);
              out_valid_d = 1'b1;
            end
          end else begin
            unique case (phase_q)
              PH_HEADER: begin
                if (in_nl) begin
                  phase_d   = PH_SEQ;
                  started_d = 1'b0;
                  fill_d    = '0;
                  wbank_d   = '0;
                  wrow_d    = '0;
                end else begin
                  started_d = 1'b1;
                end
                out_d       = fqrc_byte_item(in_b);
                out_valid_d = 1'b1;
              end
              PH_SEQ: begin
                if (in_nl) begin
                  phase_d = PH_PLUS;
                  state_d = ST_PREP;
                end else if (in_comp == 8'h00) begin
                  err_d       = STATUS_NON_BASE;
                  out_d       = fqrc_status_item(STATUS_NON_BASE);
                  out_valid_d = 1'b1;
                end else if (fill_q >= FILL_W'(MAX_LINE)) begin
                  err_d       = STATUS_TOO_LONG;
                  out_d       = fqrc_status_item(STATUS_TOO_LONG);
                  out_valid_d = 1'b1;
                end else begin
                  wr_en     = 1'b1;
                  wr_data   = in_comp;
                  started_d = 1'b1;
                end
              end
              PH_PLUS: begin
                if (!started_q && (in_b != CHAR_PLUS)) begin
                  err_d       = STATUS_NO_PLUS;
                  out_d       = fqrc_status_item(STATUS_NO_PLUS);
                  out_valid_d = 1'b1;
                end else begin
                  if (in_nl) begin
                    phase_d   = PH_QUAL;
                    started_d = 1'b0;
                    fill_d    = '0;
                    wbank_d   = '0;
                    wrow_d    = '0;
                  end else begin
                    started_d = 1'b1;
                  end
                  out_d       = fqrc_byte_item(in_b);
                  out_valid_d = 1'b1;
                end
              end
              PH_QUAL: begin
                if (in_nl) begin
                  phase_d = PH_HEADER;
                  state_d = ST_PREP;
                end else if (fill_q >= FILL_W'(MAX_LINE)) begin
                  err_d       = STATUS_TOO_LONG;
                  out_d       = fqrc_status_item(STATUS_TOO_LONG);
                  out_valid_d = 1'b1;
                end else begin
                  wr_en     = 1'b1;
                  started_d = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
          // Advance the write pointer after a buffered byte
          if (wr_en) begin
            fill_d = fill_q + 1'b1;
            if (wbank_q == LANE_W'(OUT_LANES - 1)) begin
              wbank_d = '0;
              wrow_d  = wrow_q + 1'b1;
            end else begin
              wbank_d = wbank_q + 1'b1;
            end
          end
        end
      end
      ST_PREP: begin
        // Latch the top of the line and release the buffer for the next line
        tb_d      = top_bank;
        rc_d      = top_row;
        rem_d     = fill_q;
        fill_d    = '0;
        wbank_d   = '0;
        wrow_d    = '0;
        started_d = 1'b0;
        state_d   = ST_ISSUE;
      end
      ST_ISSUE: begin
        rd_en   = 1'b1;
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_d       = drain_item;
          out_valid_d = 1'b1;
          if (!rem_full) begin
            state_d = ST_IDLE;
          end else begin
            // Read the next row group while this result goes out
            rem_d = rem_q - FILL_W'(OUT_LANES);
            rc_d  = rc_q - 1'b1;
            rd_en = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_HEADER;
      started_q   <= 1'b0;
      err_q       <= STATUS_OK;
      fin_q       <= 1'b0;
      fill_q      <= '0;
      wbank_q     <= '0;
      wrow_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      started_q   <= started_d;
      err_q       <= err_d;
      fin_q       <= fin_d;
      fill_q      <= fill_d;
      wbank_q     <= wbank_d;
      wrow_q      <= wrow_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Drain cursor and payload: no reset needed
  always_ff @(posedge clk_i) begin
    tb_q  <= tb_d;
    rc_q  <= rc_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/fqrc_checker.sv =====
`timescale 1ns / 1ps
module fqrc_checker import fqrc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input fqrc_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input fqrc_out_t out_data_o
);

  // Hold a stalled input transaction
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Error reports carry no bytes and close the transaction group
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_OK) |->
      (out_data_o.byte_count == 4'd0) && out_data_o.last &&
      (out_data_o.out_bytes == 64'd0))
    else $error("malformed error report");

  // A non-final result is an ok result that carries data
  a_mid_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |->
      (out_data_o.status == STATUS_OK) && (out_data_o.byte_count != 4'd0))
    else $error("non-final result without data");

  // An empty result, such as the clean end marker, is final and carries no bytes
  a_end_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.byte_count == 4'd0) |->
      out_data_o.last && (out_data_o.out_bytes == 64'd0))
    else $error("empty result not final");

endmodule

bind fastq_reverse_complement_unit fqrc_checker u_fqrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
